// ===== sv/abpw_pkg.sv =====
package abpw_pkg;

	localparam int FB_BYTES  = 262144;
	localparam int AW        = $clog2(FB_BYTES);
	localparam int BANKS     = 4;
	localparam int BANK_ROWS = FB_BYTES / BANKS;
	localparam int ROW_AW    = AW - 2;

	// pixel formats
	localparam logic [1:0] FMT_565  = 2'd0;
	localparam logic [1:0] FMT_888  = 2'd1;
	localparam logic [1:0] FMT_8888 = 2'd2;
	localparam logic [1:0] FMT_BAD  = 2'd3;

	// register indexes
	localparam logic [2:0] CFG_X_RES   = 3'd0;
	localparam logic [2:0] CFG_Y_RES   = 3'd1;
	localparam logic [2:0] CFG_X_PAN   = 3'd2;
	localparam logic [2:0] CFG_Y_PAN   = 3'd3;
	localparam logic [2:0] CFG_LINE    = 3'd4;
	localparam logic [2:0] CFG_FORMAT  = 3'd5;

	localparam logic [12:0] X_RES_RST = 13'd640;
	localparam logic [12:0] Y_RES_RST = 13'd480;
	localparam logic [14:0] LINE_RST  = 15'd1280;

	// rgb565 expansion and requantization
	localparam logic [15:0] EXP5_MUL = 16'd527;
	localparam logic [15:0] EXP5_ADD = 16'd23;
	localparam logic [15:0] EXP6_MUL = 16'd259;
	localparam logic [15:0] EXP6_ADD = 16'd33;
	localparam logic [15:0] RQ5_MUL  = 16'd249;
	localparam logic [15:0] RQ5_ADD  = 16'd1014;
	localparam logic [15:0] RQ6_MUL  = 16'd253;
	localparam logic [15:0] RQ6_ADD  = 16'd505;
	localparam logic [7:0]  ALPHA_MAX = 8'hFF;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		logic [2:0]    nbytes;
	} st_req_t;

	function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
		logic [2:0] n;
		unique case (fmt)
			FMT_565:  n = 3'd2;
			FMT_888:  n = 3'd3;
			default:  n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

// ===== sv/abpw_store.sv =====
module abpw_store (
	input  logic                  clk,
	input  logic                  arst_n,
	input  abpw_pkg::st_req_t     req,
	input  logic [31:0]           wdata,
	output logic [31:0]           rdata,
	output logic                  ready
);

	logic                        clearing_q;
	logic [abpw_pkg::ROW_AW-1:0] clr_row_q;
	logic [1:0]                  lo_q;
	logic [7:0]                  bank_rd [abpw_pkg::BANKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == abpw_pkg::ROW_AW'(abpw_pkg::BANK_ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= req.addr[1:0];
	end

	for (genvar b = 0; b < abpw_pkg::BANKS; b++) begin : g_bank
		logic [1:0]                  off;
		logic [abpw_pkg::AW-1:0]     baddr;
		logic [abpw_pkg::ROW_AW-1:0] row;
		logic                        we;
		logic [7:0]                  wd;
		logic [7:0]                  mem [abpw_pkg::BANK_ROWS];
		logic [7:0]                  rd_q;

		always_comb begin
			off   = 2'(b) - req.addr[1:0];
			baddr = req.addr + abpw_pkg::AW'(off);
			row   = clearing_q ? clr_row_q : baddr[abpw_pkg::AW-1:2];
			we    = clearing_q || (req.we && ({1'b0, off} < req.nbytes));
			wd    = clearing_q ? 8'h00 : wdata[{off, 3'b000} +: 8];
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem[row] <= wd;
			end
			rd_q <= mem[row];
		end

		assign bank_rd[b] = rd_q;
	end

	always_comb begin
		for (int i = 0; i < abpw_pkg::BANKS; i++) begin
			rdata[8*i +: 8] = bank_rd[2'(lo_q + 2'(i))];
		end
	end

	assign ready = !clearing_q;

endmodule

// ===== sv/abpw_addr.sv =====
module abpw_addr (
	input  logic                    clk,
	input  logic [12:0]             pixel_x,
	input  logic [12:0]             pixel_y,
	input  logic                    skip_pixel,
	input  logic [12:0]             x_res,
	input  logic [12:0]             y_res,
	input  logic [11:0]             x_pan,
	input  logic [11:0]             y_pan,
	input  logic [14:0]             line_bytes,
	input  logic [1:0]              fmt,
	output logic [abpw_pkg::AW-1:0] addr_s2,
	output logic                    ok_s2
);

	logic [13:0] xs;
	logic [13:0] ys;
	logic [15:0] xoff;
	logic [28:0] prod;
	logic        ok;

	logic [28:0] prod_s1;
	logic [15:0] xoff_s1;
	logic        ok_s1;

	logic [29:0] sum;
	logic [29:0] lim;

	always_comb begin
		xs = {1'b0, pixel_x} + {2'b00, x_pan};
		ys = {1'b0, pixel_y} + {2'b00, y_pan};
		unique case (fmt)
			abpw_pkg::FMT_565: xoff = {1'b0, xs, 1'b0};
			abpw_pkg::FMT_888: xoff = {1'b0, xs, 1'b0} + {2'b00, xs};
			default:           xoff = {xs, 2'b00};
		endcase
		prod = {15'd0, ys} * {14'd0, line_bytes};
		ok   = !skip_pixel && (pixel_x < x_res) && (pixel_y < y_res)
			&& (fmt != abpw_pkg::FMT_BAD);
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		xoff_s1 <= xoff;
		ok_s1   <= ok;
	end

	always_comb begin
		sum = {1'b0, prod_s1} + {14'd0, xoff_s1};
		lim = 30'(abpw_pkg::FB_BYTES) - {27'd0, abpw_pkg::bytes_per_pixel(fmt)};
	end

	always_ff @(posedge clk) begin
		addr_s2 <= sum[abpw_pkg::AW-1:0];
		ok_s2   <= ok_s1 && (sum <= lim);
	end

endmodule

// ===== sv/abpw_blend.sv =====
module abpw_blend (
	input  logic        clk,
	input  logic [31:0] rdata,
	input  logic [1:0]  fmt,
	input  logic [23:0] fg_rgb,
	input  logic [7:0]  alpha,
	output logic [31:0] old_s4,
	output logic [31:0] new_s4
);

	// channel 0 red, 1 green, 2 blue
	logic [31:0] old_c;
	logic [7:0]  bg_c [3];
	logic [31:0] old_s1;
	logic [7:0]  bg_s1 [3];

	logic [15:0] sum_c [3];
	logic [31:0] old_s2;
	logic [15:0] sum_s2 [3];

	logic [23:0] est [3];
	logic [7:0]  q0 [3];
	logic [16:0] rem [3];
	logic [7:0]  mix_c [3];
	logic [31:0] old_s3;
	logic [7:0]  mix_s3 [3];

	logic [4:0]  r5;
	logic [5:0]  g6;
	logic [4:0]  b5;
	logic [31:0] new_c;

	// unpack background
	always_comb begin
		unique case (fmt)
			abpw_pkg::FMT_565: old_c = {16'd0, rdata[15:0]};
			abpw_pkg::FMT_888: old_c = {8'd0, rdata[23:0]};
			default:           old_c = rdata;
		endcase
		if (fmt == abpw_pkg::FMT_565) begin
			bg_c[0] = 8'(({11'd0, rdata[15:11]} * abpw_pkg::EXP5_MUL + abpw_pkg::EXP5_ADD) >> 6);
			bg_c[1] = 8'(({10'd0, rdata[10:5]} * abpw_pkg::EXP6_MUL + abpw_pkg::EXP6_ADD) >> 6);
			bg_c[2] = 8'(({11'd0, rdata[4:0]} * abpw_pkg::EXP5_MUL + abpw_pkg::EXP5_ADD) >> 6);
		end else begin
			bg_c[0] = rdata[7:0];
			bg_c[1] = rdata[15:8];
			bg_c[2] = rdata[23:16];
		end
	end

	always_ff @(posedge clk) begin
		old_s1 <= old_c;
		bg_s1  <= bg_c;
	end

	// weighted sum
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = {8'd0, alpha} * {8'd0, fg_rgb[8*(2-c) +: 8]}
				+ {8'd0, abpw_pkg::ALPHA_MAX - alpha} * {8'd0, bg_s1[c]};
		end
	end

	always_ff @(posedge clk) begin
		old_s2 <= old_s1;
		sum_s2 <= sum_c;
	end

	// divide by 255: reciprocal estimate, one correction step
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			est[c]   = {8'd0, sum_s2[c]} + {sum_s2[c], 8'd0};
			q0[c]    = est[c][23:16];
			rem[c]   = {1'b0, sum_s2[c]} - {1'b0, q0[c], 8'd0} + {9'd0, q0[c]};
			mix_c[c] = q0[c] + {7'd0, (rem[c] >= 17'd255)};
		end
	end

	always_ff @(posedge clk) begin
		old_s3 <= old_s2;
		mix_s3 <= mix_c;
	end

	// repack
	always_comb begin
		r5 = 5'(({8'd0, mix_s3[0]} * abpw_pkg::RQ5_MUL + abpw_pkg::RQ5_ADD) >> 11);
		g6 = 6'(({8'd0, mix_s3[1]} * abpw_pkg::RQ6_MUL + abpw_pkg::RQ6_ADD) >> 10);
		b5 = 5'(({8'd0, mix_s3[2]} * abpw_pkg::RQ5_MUL + abpw_pkg::RQ5_ADD) >> 11);
		if (fmt == abpw_pkg::FMT_565) begin
			new_c = {16'd0, r5, g6, b5};
		end else begin
			new_c = {8'd0, mix_s3[2], mix_s3[1], mix_s3[0]};
		end
	end

	always_ff @(posedge clk) begin
		old_s4 <= old_s3;
		new_s4 <= new_c;
	end

endmodule

// ===== sv/alpha_blend_pixel_writer.sv =====
// one pixel at a time goes through the address stages, the frame store read,
// the 4-stage blend and the write back; a new item is taken only after the
// write back, which waits while result_stall holds an untaken result
// reset: registers take their reset values, then a clearing pass zeroes the
// frame store one row of four bytes a cycle, 65536 rows, with no item taken
module alpha_blend_pixel_writer (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    pixel_valid,
	output logic                    pixel_stall,
	input  logic [12:0]             pixel_x,
	input  logic [12:0]             pixel_y,
	input  logic [23:0]             fg_rgb,
	input  logic [7:0]              alpha,
	input  logic                    skip_pixel,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic                    written,
	output logic [abpw_pkg::AW-1:0] byte_address,
	output logic [31:0]             old_pixel,
	output logic [31:0]             new_pixel,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [14:0]             cfg_data
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_BUSY  = 4'b0100,
		S_WB    = 4'b1000
	} state_t;

	localparam logic [2:0] BUSY_LAST = 3'd6;

	state_t      state_q;
	logic [2:0]  cnt_q;

	logic [12:0] x_res_q;
	logic [12:0] y_res_q;
	logic [11:0] x_pan_q;
	logic [11:0] y_pan_q;
	logic [14:0] line_q;
	logic [1:0]  fmt_q;

	logic [12:0] px_q;
	logic [12:0] py_q;
	logic [23:0] fg_q;
	logic [7:0]  alpha_q;
	logic        skip_q;

	logic                    result_valid_q;
	logic                    written_q;
	logic [abpw_pkg::AW-1:0] byte_address_q;
	logic [31:0]             old_pixel_q;
	logic [31:0]             new_pixel_q;

	logic                    accept;
	logic                    wb_go;
	logic [abpw_pkg::AW-1:0] addr_s2;
	logic                    ok_s2;
	logic [31:0]             rdata;
	logic [31:0]             old_s4;
	logic [31:0]             new_s4;
	logic                    store_ready;
	abpw_pkg::st_req_t       st_req;

	assign cfg_ready   = 1'b1;
	assign pixel_stall = (state_q != S_IDLE);
	assign accept      = pixel_valid && !pixel_stall;
	assign wb_go       = (state_q == S_WB) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_res_q <= abpw_pkg::X_RES_RST;
			y_res_q <= abpw_pkg::Y_RES_RST;
			x_pan_q <= '0;
			y_pan_q <= '0;
			line_q  <= abpw_pkg::LINE_RST;
			fmt_q   <= abpw_pkg::FMT_565;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				abpw_pkg::CFG_X_RES:  x_res_q <= cfg_data[12:0];
				abpw_pkg::CFG_Y_RES:  y_res_q <= cfg_data[12:0];
				abpw_pkg::CFG_X_PAN:  x_pan_q <= cfg_data[11:0];
				abpw_pkg::CFG_Y_PAN:  y_pan_q <= cfg_data[11:0];
				abpw_pkg::CFG_LINE:   line_q  <= cfg_data;
				abpw_pkg::CFG_FORMAT: fmt_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_q    <= pixel_x;
			py_q    <= pixel_y;
			fg_q    <= fg_rgb;
			alpha_q <= alpha;
			skip_q  <= skip_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (store_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_BUSY;
						cnt_q   <= '0;
					end
				end
				S_BUSY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == BUSY_LAST) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (wb_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (wb_go) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			written_q      <= ok_s2;
			byte_address_q <= ok_s2 ? addr_s2 : '0;
			old_pixel_q    <= ok_s2 ? old_s4 : 32'd0;
			new_pixel_q    <= ok_s2 ? new_s4 : 32'd0;
		end
	end

	assign result_valid = result_valid_q;
	assign written      = written_q;
	assign byte_address = byte_address_q;
	assign old_pixel    = old_pixel_q;
	assign new_pixel    = new_pixel_q;

	always_comb begin
		st_req.we     = wb_go && ok_s2;
		st_req.addr   = addr_s2;
		st_req.nbytes = abpw_pkg::bytes_per_pixel(fmt_q);
	end

	abpw_addr u_addr (
		.clk        (clk),
		.pixel_x    (px_q),
		.pixel_y    (py_q),
		.skip_pixel (skip_q),
		.x_res      (x_res_q),
		.y_res      (y_res_q),
		.x_pan      (x_pan_q),
		.y_pan      (y_pan_q),
		.line_bytes (line_q),
		.fmt        (fmt_q),
		.addr_s2    (addr_s2),
		.ok_s2      (ok_s2)
	);

	abpw_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (st_req),
		.wdata  (new_s4),
		.rdata  (rdata),
		.ready  (store_ready)
	);

	abpw_blend u_blend (
		.clk    (clk),
		.rdata  (rdata),
		.fmt    (fmt_q),
		.fg_rgb (fg_q),
		.alpha  (alpha_q),
		.old_s4 (old_s4),
		.new_s4 (new_s4)
	);

	a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!store_ready |-> pixel_stall)
		else $error("item taken during store clear");

	a_skipped_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !written) |->
		(byte_address == '0 && old_pixel == 32'd0 && new_pixel == 32'd0))
		else $error("unwritten result carries data");

	a_result_from_wb: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == S_WB))
		else $error("result raised outside write back");

	a_write_in_wb: assert property (@(posedge clk) disable iff (!arst_n)
		st_req.we |-> (state_q == S_WB && store_ready))
		else $error("store write outside write back");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import abpw_pkg::*;

	localparam int unsigned HANG_LIMIT = 250000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned PHASE_ITEMS = 100;
	localparam int unsigned NUM_PHASES = 16;

	typedef struct {
		bit          written;
		bit [AW-1:0] addr;
		bit [31:0]   old_px;
		bit [31:0]   new_px;
	} pixel_result_t;

	class blend_tracker;
		bit [7:0]      shadow_fb [FB_BYTES];
		bit [12:0]     x_res;
		bit [12:0]     y_res;
		bit [11:0]     x_pan;
		bit [11:0]     y_pan;
		bit [14:0]     line_len;
		bit [1:0]      fmt;
		pixel_result_t due_pixels [$];
		int unsigned   fails;

		function new();
			x_res = X_RES_RST;
			y_res = Y_RES_RST;
			x_pan = '0;
			y_pan = '0;
			line_len = LINE_RST;
			fmt = FMT_565;
			fails = 0;
		endfunction

		function void set_reg(bit [2:0] idx, bit [14:0] data);
			case (idx)
				CFG_X_RES:  x_res = data[12:0];
				CFG_Y_RES:  y_res = data[12:0];
				CFG_X_PAN:  x_pan = data[11:0];
				CFG_Y_PAN:  y_pan = data[11:0];
				CFG_LINE:   line_len = data;
				CFG_FORMAT: fmt = data[1:0];
				default: ;
			endcase
		endfunction

		function int unsigned mix(int unsigned a, int unsigned f, int unsigned b);
			return (a * f + (255 - a) * b) / 255;
		endfunction

		function void note_pixel(bit [12:0] px, bit [12:0] py, bit [23:0] fg, bit [7:0] a,
				bit skip);
			pixel_result_t    res;
			int unsigned      bpp;
			longint unsigned  addr;
			bit [31:0]        oldv;
			bit [31:0]        newv;
			int unsigned      br, bg, bb, r, g, b, r5, g6, b5;
			res.written = 1'b0;
			res.addr = '0;
			res.old_px = '0;
			res.new_px = '0;
			case (fmt)
				FMT_565:  bpp = 2;
				FMT_888:  bpp = 3;
				FMT_8888: bpp = 4;
				default:  bpp = 0;
			endcase
			if (bpp != 0 && !skip && px < x_res && py < y_res) begin
				addr = (64'(px) + 64'(x_pan)) * 64'(bpp)
					+ (64'(py) + 64'(y_pan)) * 64'(line_len);
				if (addr <= 64'(FB_BYTES) - 64'(bpp)) begin
					oldv = '0;
					for (int i = 0; i < bpp; i++)
						oldv = oldv | (32'(shadow_fb[addr + i]) << (8 * i));
					if (bpp == 2) begin
						br = (32'(oldv[15:11]) * 32'(EXP5_MUL) + 32'(EXP5_ADD)) >> 6;
						bg = (32'(oldv[10:5]) * 32'(EXP6_MUL) + 32'(EXP6_ADD)) >> 6;
						bb = (32'(oldv[4:0]) * 32'(EXP5_MUL) + 32'(EXP5_ADD)) >> 6;
					end else begin
						br = 32'(oldv[7:0]);
						bg = 32'(oldv[15:8]);
						bb = 32'(oldv[23:16]);
					end
					r = mix(32'(a), 32'(fg[23:16]), br);
					g = mix(32'(a), 32'(fg[15:8]), bg);
					b = mix(32'(a), 32'(fg[7:0]), bb);
					if (bpp == 2) begin
						r5 = (r * 32'(RQ5_MUL) + 32'(RQ5_ADD)) >> 11;
						g6 = (g * 32'(RQ6_MUL) + 32'(RQ6_ADD)) >> 10;
						b5 = (b * 32'(RQ5_MUL) + 32'(RQ5_ADD)) >> 11;
						newv = {16'd0, r5[4:0], g6[5:0], b5[4:0]};
					end else begin
						newv = {8'd0, b[7:0], g[7:0], r[7:0]};
					end
					for (int i = 0; i < bpp; i++)
						shadow_fb[addr + i] = newv[8 * i +: 8];
					res.written = 1'b1;
					res.addr = addr[AW-1:0];
					res.old_px = oldv;
					res.new_px = newv;
				end
			end
			due_pixels.push_back(res);
		endfunction

		task report(string what);
			if (fails < 100)
				$display("mismatch at %0t: %s", $time, what);
			fails++;
		endtask

		task check_pixel(logic w, logic [AW-1:0] a, logic [31:0] o, logic [31:0] n);
			pixel_result_t e;
			if (due_pixels.size() == 0) begin
				report($sformatf("unexpected item addr %h", a));
			end else begin
				e = due_pixels.pop_front();
				if (w !== e.written)
					report($sformatf("written %b, want %b", w, e.written));
				if (a !== e.addr)
					report($sformatf("byte_address %h, want %h", a, e.addr));
				if (o !== e.old_px)
					report($sformatf("old_pixel %h, want %h at %h", o, e.old_px, e.addr));
				if (n !== e.new_px)
					report($sformatf("new_pixel %h, want %h at %h", n, e.new_px, e.addr));
			end
		endtask

		function int unsigned pending();
			return due_pixels.size();
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          pixel_valid;
	logic          pixel_stall;
	logic [12:0]   pixel_x;
	logic [12:0]   pixel_y;
	logic [23:0]   fg_rgb;
	logic [7:0]    alpha;
	logic          skip_pixel;
	logic          result_valid;
	logic          result_stall;
	logic          written;
	logic [AW-1:0] byte_address;
	logic [31:0]   old_pixel;
	logic [31:0]   new_pixel;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [2:0]    cfg_index;
	logic [14:0]   cfg_data;

	blend_tracker  sb;
	bit            steady;
	int unsigned   quiet_cycles;

	alpha_blend_pixel_writer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.fg_rgb       (fg_rgb),
		.alpha        (alpha),
		.skip_pixel   (skip_pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.written      (written),
		.byte_address (byte_address),
		.old_pixel    (old_pixel),
		.new_pixel    (new_pixel),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic bit [12:0] pick_coord(int unsigned res);
		int unsigned lim;
		lim = (res > 8191) ? 8191 : res;
		case ($urandom_range(0, 19))
			0, 1:          return 13'($urandom_range(0, 8191));
			2:             return 13'd8191;
			3, 4, 5, 6, 7: return 13'($urandom_range(0, (lim < 3) ? lim : 3));
			default:       return 13'($urandom_range(0, lim));
		endcase
	endfunction

	task automatic send_pixel(bit [12:0] px, bit [12:0] py, bit [23:0] fg, bit [7:0] a,
			bit skip);
		int unsigned gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			pixel_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_x <= px;
		pixel_y <= py;
		fg_rgb <= fg;
		alpha <= a;
		skip_pixel <= skip;
		do @(posedge clk); while (pixel_stall);
		sb.note_pixel(px, py, fg, a, skip);
	endtask

	task automatic write_reg(bit [2:0] idx, bit [14:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		pixel_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(bit [1:0] f, int unsigned xr, int unsigned yr,
			int unsigned xp, int unsigned yp, int unsigned lb);
		drain();
		write_reg(CFG_X_RES, 15'(xr));
		write_reg(CFG_Y_RES, 15'(yr));
		write_reg(CFG_X_PAN, 15'(xp));
		write_reg(CFG_Y_PAN, 15'(yp));
		write_reg(CFG_LINE, 15'(lb));
		write_reg(CFG_FORMAT, 15'(f));
	endtask

	task automatic random_pixels(int unsigned n);
		bit [23:0] fg;
		bit [7:0]  a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0:       fg = 24'h000000;
				1:       fg = 24'hFFFFFF;
				default: fg = 24'($urandom_range(0, 24'hFFFFFF));
			endcase
			case ($urandom_range(0, 9))
				0:       a = 8'd0;
				1:       a = ALPHA_MAX;
				default: a = 8'($urandom_range(0, 255));
			endcase
			send_pixel(pick_coord(32'(sb.x_res)), pick_coord(32'(sb.y_res)), fg, a,
				$urandom_range(0, 9) == 0);
		end
	endtask

	task automatic random_config();
		bit [1:0]    f;
		int unsigned xr, yr, xp, yp, lb;
		f = ($urandom_range(0, 9) == 0) ? FMT_BAD : 2'($urandom_range(0, 2));
		if ($urandom_range(0, 3) == 0) begin
			xr = $urandom_range(0, 8191);
			yr = $urandom_range(0, 8191);
			xp = $urandom_range(0, 4095);
			yp = $urandom_range(0, 63);
			lb = $urandom_range(1, 32767);
		end else begin
			xr = $urandom_range(1, 24);
			yr = $urandom_range(1, 12);
			xp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 30);
			yp = $urandom_range(0, 20);
			lb = $urandom_range(1, 200);
		end
		set_config(f, xr, yr, xp, yp, lb);
	endtask

	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 7) == 0)
				repeat ($urandom_range(100, 300)) @(negedge clk);
			else
				repeat ($urandom_range(0, 30)) @(negedge clk);
			if ($urandom_range(0, 9) < 7) begin
				@(negedge clk);
				result_stall <= 1'b1;
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_pixel(written, byte_address, old_pixel, new_pixel);
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		sb = new();
		steady = 1'b0;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel_x = '0;
		pixel_y = '0;
		fg_rgb = '0;
		alpha = '0;
		skip_pixel = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// default registers: 640x480 rgb565, pitch 1280
		send_pixel(13'd0, 13'd0, 24'hFFFFFF, 8'd255, 1'b0);
		send_pixel(13'd0, 13'd0, 24'h000000, 8'd0, 1'b0);
		send_pixel(13'd0, 13'd0, 24'h123456, 8'd128, 1'b0);
		send_pixel(13'd1, 13'd0, 24'h000000, 8'd255, 1'b0);
		send_pixel(13'd1, 13'd0, 24'hA5A5A5, 8'd1, 1'b0);
		send_pixel(13'd639, 13'd0, 24'h00FF00, 8'd200, 1'b0);
		send_pixel(13'd640, 13'd0, 24'hFFFFFF, 8'd255, 1'b0);
		send_pixel(13'd0, 13'd480, 24'hFFFFFF, 8'd255, 1'b0);
		send_pixel(13'd0, 13'd479, 24'hFFFFFF, 8'd255, 1'b0);
		send_pixel(13'd511, 13'd204, 24'hFF0000, 8'd255, 1'b0);
		send_pixel(13'd512, 13'd204, 24'hFF0000, 8'd255, 1'b0);
		send_pixel(13'd8191, 13'd8191, 24'hFFFFFF, 8'd255, 1'b0);
		send_pixel(13'd1, 13'd1, 24'hFFFFFF, 8'd255, 1'b1);
		send_pixel(13'd511, 13'd204, 24'h0000FF, 8'd77, 1'b0);

		for (int p = 0; p < NUM_PHASES; p++) begin
			steady = ($urandom_range(0, 3) == 0);
			case (p)
				0:       set_config(FMT_565, 16, 8, 0, 0, 32);
				1:       set_config(FMT_888, 12, 6, 3, 2, 45);
				2:       set_config(FMT_8888, 8, 8, 0, 0, 32);
				3:       set_config(FMT_BAD, 16, 8, 0, 0, 32);
				4:       set_config(FMT_565, 0, 4096, 0, 0, 64);
				5:       set_config(FMT_8888, 8191, 8191, 4095, 4095, 32767);
				6:       set_config(FMT_888, 4096, 1, 4095, 0, 1);
				7:       set_config(FMT_565, 4096, 16, 0, 0, 16384);
				default: random_config();
			endcase
			random_pixels(PHASE_ITEMS);
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
